/* rtl/trm_pkg.sv */
package trm_pkg;

  localparam int POS_BITS_DEF   = 24;
  localparam int VEL_BITS_DEF   = 20;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 40;
  localparam int STAMP_BITS    = 63;
  localparam int EPOCH_BITS    = 32;
  localparam int CNT_BITS      = 32;
  localparam int DUR_BITS      = 40;
  localparam int SPEED_BITS    = 21;
  localparam int DELTA_BITS    = 16;
  localparam int CAUSE_BITS    = 2;
  localparam int ACC_BITS      = 32;
  localparam int CORDIC_STEPS  = 32;
  localparam int STEP_BITS     = 5;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BEARING_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CLOSING_SPEED = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECOVERY_SPEED    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NO_CLOSING_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_RESEED_GAP    = 3'd4;

  // reseed causes
  localparam logic [CAUSE_BITS-1:0] CAUSE_NONE    = 2'd0;
  localparam logic [CAUSE_BITS-1:0] CAUSE_BEARING = 2'd1;
  localparam logic [CAUSE_BITS-1:0] CAUSE_STALL   = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture input and start the units
    logic step;     // run one iteration of cordic / sqrt / divide
    logic finish;   // update episode state and form the result
  } trm_cmd_t;

  typedef struct packed {
    logic invalid;  // observation resets the episode
  } trm_sts_t;

  function automatic logic [ACC_BITS-1:0] turn_angle(input logic [STEP_BITS-1:0] i);
    logic [ACC_BITS-1:0] a;
    case (i)
      5'd0:  a = 32'h20000000; 5'd1:  a = 32'h12E4051E; 5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4; 5'd4:  a = 32'h028B0D43; 5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E; 5'd7:  a = 32'h00517C55; 5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F; 5'd10: a = 32'h000A2F98; 5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6; 5'd13: a = 32'h000145F3; 5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D; 5'd16: a = 32'h000028BE; 5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30; 5'd19: a = 32'h00000518; 5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146; 5'd22: a = 32'h000000A3; 5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029; 5'd25: a = 32'h00000014; 5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005; 5'd28: a = 32'h00000003; 5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

/* rtl/trm_if.sv */
interface trm_in_if #(
  parameter int POS_BITS = trm_pkg::POS_BITS_DEF,
  parameter int VEL_BITS = trm_pkg::VEL_BITS_DEF
);
  logic valid;
  logic ready;
  logic active;
  logic [trm_pkg::STAMP_BITS-1:0] stamp;
  logic [trm_pkg::EPOCH_BITS-1:0] sight_epoch;
  logic signed [POS_BITS-1:0] rel_pos_x;
  logic signed [POS_BITS-1:0] rel_pos_y;
  logic signed [POS_BITS-1:0] rel_pos_z;
  logic signed [VEL_BITS-1:0] rel_vel_x;
  logic signed [VEL_BITS-1:0] rel_vel_y;
  logic signed [VEL_BITS-1:0] rel_vel_z;

  modport source (output valid, active, stamp, sight_epoch, rel_pos_x, rel_pos_y,
                  rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z, input ready);
  modport sink (input valid, active, stamp, sight_epoch, rel_pos_x, rel_pos_y,
                rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z, output ready);
endinterface

interface trm_out_if;
  logic valid;
  logic ready;
  logic reseed_req;
  logic [trm_pkg::CAUSE_BITS-1:0] reseed_cause;
  logic [trm_pkg::CNT_BITS-1:0] reseed_count;
  logic signed [trm_pkg::DELTA_BITS-1:0] bearing_delta;
  logic signed [trm_pkg::SPEED_BITS-1:0] closing_speed;
  logic [trm_pkg::DUR_BITS-1:0] stall_time;

  modport source (output valid, reseed_req, reseed_cause, reseed_count, bearing_delta,
                  closing_speed, stall_time, input ready);
  modport sink (input valid, reseed_req, reseed_cause, reseed_count, bearing_delta,
                closing_speed, stall_time, output ready);
endinterface

/* rtl/trm_datapath.sv */
module trm_datapath #(
  parameter int POS_BITS   = trm_pkg::POS_BITS_DEF,
  parameter int VEL_BITS   = trm_pkg::VEL_BITS_DEF,
  parameter int ANGLE_BITS = trm_pkg::ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  trm_pkg::trm_cmd_t cmd,
  output trm_pkg::trm_sts_t sts,
  input  logic [trm_pkg::STEP_BITS-1:0] step_idx,
  // observation
  input  logic active,
  input  logic [trm_pkg::STAMP_BITS-1:0] stamp,
  input  logic [trm_pkg::EPOCH_BITS-1:0] sight_epoch,
  input  logic signed [POS_BITS-1:0] rel_pos_x,
  input  logic signed [POS_BITS-1:0] rel_pos_y,
  input  logic signed [POS_BITS-1:0] rel_pos_z,
  input  logic signed [VEL_BITS-1:0] rel_vel_x,
  input  logic signed [VEL_BITS-1:0] rel_vel_y,
  input  logic signed [VEL_BITS-1:0] rel_vel_z,
  // configuration
  input  logic [15:0] bearing_threshold,
  input  logic signed [trm_pkg::SPEED_BITS-1:0] min_closing_speed,
  input  logic signed [trm_pkg::SPEED_BITS-1:0] recovery_speed,
  input  logic [trm_pkg::DUR_BITS-1:0] no_closing_limit,
  input  logic [trm_pkg::DUR_BITS-1:0] min_reseed_gap,
  // result
  output logic reseed_req,
  output logic [trm_pkg::CAUSE_BITS-1:0] reseed_cause,
  output logic [trm_pkg::CNT_BITS-1:0] reseed_count,
  output logic signed [trm_pkg::DELTA_BITS-1:0] bearing_delta,
  output logic signed [trm_pkg::SPEED_BITS-1:0] closing_speed,
  output logic [trm_pkg::DUR_BITS-1:0] stall_time
);

  localparam int CW   = 58;                // cordic x/y width
  localparam int PRE  = 56 - POS_BITS;
  localparam int SQW  = 2 * POS_BITS + 2;  // sum of squares width
  localparam int RW   = POS_BITS + 1;      // root width
  localparam int DOTW = POS_BITS + VEL_BITS + 2;
  localparam int ACCW = trm_pkg::ACC_BITS;
  localparam int SW   = trm_pkg::STAMP_BITS;

  // captured observation
  logic [SW-1:0] stamp_q;
  logic [trm_pkg::EPOCH_BITS-1:0] epoch_q;
  logic signed [POS_BITS-1:0] pz_q;
  logic signed [VEL_BITS-1:0] vx_q, vy_q, vz_q;
  logic signed [POS_BITS-1:0] px_q, py_q;
  logic invalid_q;

  // cordic
  logic signed [CW-1:0] cx, cy;
  logic [ACCW-1:0] cacc;

  // square root, restoring
  logic [SQW-1:0] sq_sum, sq_rem;
  logic [RW-1:0]  sq_root;
  logic [1:0]     sq_phase;  // 0 products and sum, 2 run root, 3 set up divide, 1 divide

  // dot product and divider
  logic signed [DOTW-1:0] dot;
  logic [DOTW:0] div_num;   // 2*|dot| + r
  logic [DOTW:0] div_rem;
  logic [DOTW:0] div_quo;
  logic [DOTW:0] div_den;   // 2*r
  logic [$clog2(DOTW+2)-1:0] div_cnt;
  logic div_run;
  logic [SQW-1:0] r2_q;

  // multiply stages (a square and a dot term per step, registered)
  logic signed [2*POS_BITS-1:0] prod_p;
  logic signed [POS_BITS+VEL_BITS-1:0] prod_d;
  logic [2:0] mul_sel;

  // episode state
  logic [trm_pkg::EPOCH_BITS-1:0] episode_epoch;
  logic [SW-1:0] stall_start, last_reseed_time;
  logic [ANGLE_BITS-1:0] ref_bearing;
  logic ref_valid, stall_reseeded;
  logic [trm_pkg::CNT_BITS-1:0] reseed_counter;

  assign sts.invalid = invalid_q;

  // capture input and run iterative units
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stamp_q   <= stamp;
      epoch_q   <= sight_epoch;
      px_q      <= rel_pos_x;
      py_q      <= rel_pos_y;
      pz_q      <= rel_pos_z;
      vx_q      <= rel_vel_x;
      vy_q      <= rel_vel_y;
      vz_q      <= rel_vel_z;
      invalid_q <= !active || stamp == '0 || sight_epoch == '0 ||
                   (rel_pos_x == '0 && rel_pos_y == '0);
      if (rel_pos_x < 0) begin
        cx   <= -(CW'(rel_pos_x) <<< PRE);
        cy   <= -(CW'(rel_pos_y) <<< PRE);
        cacc <= 32'h80000000;
      end else begin
        cx   <= CW'(rel_pos_x) <<< PRE;
        cy   <= CW'(rel_pos_y) <<< PRE;
        cacc <= '0;
      end
      mul_sel  <= '0;
      sq_sum   <= '0;
      dot      <= '0;
      sq_phase <= 2'd0;
      div_run  <= 1'b0;
    end else if (cmd.step) begin
      // one cordic rotation
      if (!cy[CW-1]) begin
        cx   <= cx + (cy >>> step_idx);
        cy   <= cy - (cx >>> step_idx);
        cacc <= cacc + trm_pkg::turn_angle(step_idx);
      end else begin
        cx   <= cx - (cy >>> step_idx);
        cy   <= cy + (cx >>> step_idx);
        cacc <= cacc - trm_pkg::turn_angle(step_idx);
      end
      // sequence products, then root, then divide
      if (mul_sel < 3'd7) mul_sel <= mul_sel + 3'd1;
      case (mul_sel)
        3'd0: begin prod_p <= px_q * px_q; prod_d <= px_q * vx_q; end
        3'd1: begin prod_p <= py_q * py_q; prod_d <= py_q * vy_q; end
        3'd2: begin prod_p <= pz_q * pz_q; prod_d <= pz_q * vz_q; end
        default: ;
      endcase
      if (mul_sel >= 3'd1 && mul_sel <= 3'd3) begin
        sq_sum <= sq_sum + SQW'(unsigned'(prod_p));
        dot    <= dot + DOTW'(prod_d);
      end
      if (mul_sel == 3'd4) begin
        r2_q     <= sq_sum;
        sq_rem   <= sq_sum;
        sq_root  <= '0;
        sq_phase <= 2'd2;
        div_cnt  <= '0;
      end
      if (sq_phase == 2'd2 && !div_run) begin
        // restoring sqrt: one result bit per step, from the top
        logic [SQW-1:0] trial;
        logic [RW-1:0] bitv;
        trial = '0;
        bitv = RW'(1) << (RW - 1 - int'(div_cnt));
        trial = SQW'(((SQW)'(sq_root) << 1) | SQW'(bitv)) << (RW - 1 - int'(div_cnt));
        if (sq_rem >= trial) begin
          sq_rem  <= sq_rem - trial;
          sq_root <= sq_root | bitv;
        end
        if (int'(div_cnt) == RW - 1) begin
          div_cnt <= '0;
          div_run <= 1'b1;
          sq_phase <= 2'd3;
        end else begin
          div_cnt <= div_cnt + 1'b1;
        end
      end
      if (sq_phase == 2'd3 && div_run) begin
        // round root to nearest, set up divide
        logic [RW-1:0] rr;
        rr = (sq_rem > SQW'(sq_root)) ? sq_root + 1'b1 : sq_root;
        div_den <= (DOTW+1)'(rr) << 1;
        div_num <= ((DOTW+1)'(dot[DOTW-1] ? -dot : dot) << 1) + (DOTW+1)'(rr);
        div_rem <= '0;
        div_quo <= '0;
        div_cnt <= '0;
        sq_phase <= 2'd1;
      end else if (sq_phase == 2'd1 && div_run) begin
        // restoring divide, one quotient bit per step
        logic [DOTW+1:0] rem2;
        rem2 = {div_rem, div_num[DOTW]};
        div_num <= div_num << 1;
        if (rem2 >= (DOTW+2)'(div_den)) begin
          div_rem <= (DOTW+1)'(rem2 - (DOTW+2)'(div_den));
          div_quo <= {div_quo[DOTW-1:0], 1'b1};
        end else begin
          div_rem <= rem2[DOTW:0];
          div_quo <= {div_quo[DOTW-1:0], 1'b0};
        end
        if (int'(div_cnt) == DOTW) div_run <= 1'b0;
        else div_cnt <= div_cnt + 1'b1;
      end
    end
  end

  // closing speed, bearing, delta, stall time and reseed decisions from finished units
  logic [DOTW:0] q_sat;
  logic signed [trm_pkg::SPEED_BITS-1:0] closing;
  logic [ANGLE_BITS-1:0] bearing, dlt_raw;
  logic [ACCW-1:0] acc_rnd;
  logic signed [ANGLE_BITS-1:0] delta;
  logic [ANGLE_BITS-1:0] delta_mag;
  logic [SW:0] dur_full;
  logic [SW-1:0] start_eff, dur;
  logic renew, recover, stalled, blocked, fire_b, fire_s;
  logic [SW:0] gap_end;
  logic ref_valid_eff, reseeded_eff;
  logic [SW-1:0] last_eff;
  logic [ANGLE_BITS-1:0] ref_eff;

  always_comb begin
    q_sat = (div_quo > (DOTW+1)'(1048576)) ? (DOTW+1)'(1048576) : div_quo;
    if (dot[DOTW-1]) closing = -trm_pkg::SPEED_BITS'(q_sat);
    else if (q_sat > (DOTW+1)'(1048575)) closing = 21'sd1048575;
    else closing = trm_pkg::SPEED_BITS'(q_sat);

    acc_rnd = cacc + (ACCW'(1) << (ACCW - 1 - ANGLE_BITS));
    bearing = acc_rnd[ACCW-1 -: ANGLE_BITS];

    renew = episode_epoch != epoch_q;
    ref_valid_eff = renew | ref_valid;
    ref_eff  = renew ? bearing : ref_bearing;
    last_eff = renew ? '0 : last_reseed_time;
    reseeded_eff = renew ? 1'b0 : stall_reseeded;
    start_eff = renew ? '0 : stall_start;
    dlt_raw = bearing - ref_eff;
    delta = ref_valid_eff ? signed'(dlt_raw) : '0;
    delta_mag = delta[ANGLE_BITS-1] ? -delta : delta;

    recover = closing >= recovery_speed;
    stalled = !recover && closing <= min_closing_speed;
    if (stalled && start_eff == '0) start_eff = stamp_q;
    if (!stalled) start_eff = '0;
    dur_full = {1'b0, stamp_q} - {1'b0, start_eff};
    dur = (stalled && !dur_full[SW]) ? dur_full[SW-1:0] : '0;

    gap_end = {1'b0, last_eff} + (SW+1)'(min_reseed_gap);
    blocked = last_eff != '0 && ({1'b0, stamp_q} < gap_end);
    fire_b = !blocked && (ANGLE_BITS+1)'(delta_mag) >= (ANGLE_BITS+1)'(bearing_threshold);
    fire_s = !blocked && !fire_b && !(reseeded_eff && !recover) && start_eff != '0 &&
             dur >= SW'(no_closing_limit);
  end

  // update episode state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      episode_epoch    <= '0;
      stall_start      <= '0;
      last_reseed_time <= '0;
      ref_bearing      <= '0;
      ref_valid        <= 1'b0;
      stall_reseeded   <= 1'b0;
      reseed_counter   <= '0;
    end else if (cmd.finish) begin
      reseed_req   <= 1'b0;
      reseed_cause <= trm_pkg::CAUSE_NONE;
      reseed_count <= reseed_counter;
      if (invalid_q) begin
        bearing_delta    <= '0;
        closing_speed    <= '0;
        stall_time       <= '0;
        episode_epoch    <= '0;
        stall_start      <= '0;
        last_reseed_time <= '0;
        ref_bearing      <= '0;
        ref_valid        <= 1'b0;
        stall_reseeded   <= 1'b0;
      end else begin
        bearing_delta  <= trm_pkg::DELTA_BITS'(delta);
        closing_speed  <= closing;
        stall_time     <= (dur > SW'({trm_pkg::DUR_BITS{1'b1}})) ? '1 : dur[trm_pkg::DUR_BITS-1:0];
        episode_epoch  <= epoch_q;
        ref_valid      <= ref_valid_eff;
        ref_bearing    <= fire_b ? bearing : ref_eff;
        stall_reseeded <= recover ? 1'b0 : (reseeded_eff | fire_s);
        stall_start    <= (fire_b && start_eff != '0) ? stamp_q : start_eff;
        last_reseed_time <= (fire_b || fire_s) ? stamp_q : last_eff;
        if (fire_b || fire_s) begin
          reseed_counter <= reseed_counter + 1'b1;
          reseed_count   <= reseed_counter + 1'b1;
          reseed_req     <= 1'b1;
          reseed_cause   <= fire_b ? trm_pkg::CAUSE_BEARING : trm_pkg::CAUSE_STALL;
        end
      end
    end
  end

endmodule

/* rtl/trm_ctrl.sv */
module trm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output trm_pkg::trm_cmd_t cmd,
  input  trm_pkg::trm_sts_t sts,
  output logic [trm_pkg::STEP_BITS-1:0] step_idx
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  localparam int RUN_CYCLES = 120;

  state_t state, state_next;
  logic [6:0] cnt;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign step_idx  = cnt[trm_pkg::STEP_BITS-1:0] | {trm_pkg::STEP_BITS{cnt >= 7'd32}};

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_next = S_RUN; end
      S_RUN: begin
        cmd.step = 1'b1;
        if (int'(cnt) == RUN_CYCLES - 1 || sts.invalid) state_next = S_FIN;
      end
      S_FIN: begin cmd.finish = 1'b1; state_next = S_OUT; end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // advance sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_RUN) cnt <= cnt + 1'b1;
      else cnt <= '0;
    end
  end

endmodule

/* rtl/tracking_reseed_monitor.sv */
// Tracking reseed monitor: takes one observation at a time and returns one result
// per observation, formed by the iterative units run one after another by the
// controller: the 32-step CORDIC runs alongside three products, a bit-serial square
// root and a bit-serial divide of the dot product by the range. Invalid observations
// cut the run short and go straight to the finish state. Configuration is written
// through the index/data port; keeping writes to idle is up to the user, the block does not enforce it.
module tracking_reseed_monitor #(
  parameter int POS_BITS   = trm_pkg::POS_BITS_DEF,
  parameter int VEL_BITS   = trm_pkg::VEL_BITS_DEF,
  parameter int ANGLE_BITS = trm_pkg::ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  trm_in_if.sink   obs,
  trm_out_if.source res,
  input  logic cfg_we,
  input  logic [trm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [trm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  trm_pkg::trm_cmd_t cmd;
  trm_pkg::trm_sts_t sts;
  logic [trm_pkg::STEP_BITS-1:0] step_idx;

  logic [15:0] bearing_threshold;
  logic signed [trm_pkg::SPEED_BITS-1:0] min_closing_speed, recovery_speed;
  logic [trm_pkg::DUR_BITS-1:0] no_closing_limit, min_reseed_gap;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bearing_threshold <= 16'd2731;
      min_closing_speed <= '0;
      recovery_speed    <= 21'sd500;
      no_closing_limit  <= 40'd2000000000;
      min_reseed_gap    <= 40'd1000000000;
    end else if (cfg_we) begin
      case (cfg_index)
        trm_pkg::REG_BEARING_THRESHOLD: bearing_threshold <= cfg_data[15:0];
        trm_pkg::REG_MIN_CLOSING_SPEED: min_closing_speed <= cfg_data[trm_pkg::SPEED_BITS-1:0];
        trm_pkg::REG_RECOVERY_SPEED:    recovery_speed <= cfg_data[trm_pkg::SPEED_BITS-1:0];
        trm_pkg::REG_NO_CLOSING_LIMIT:  no_closing_limit <= cfg_data;
        trm_pkg::REG_MIN_RESEED_GAP:    min_reseed_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  trm_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(obs.valid), .in_ready(obs.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .cmd, .sts, .step_idx
  );

  trm_datapath #(.POS_BITS(POS_BITS), .VEL_BITS(VEL_BITS), .ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .step_idx,
    .active(obs.active), .stamp(obs.stamp), .sight_epoch(obs.sight_epoch),
    .rel_pos_x(obs.rel_pos_x), .rel_pos_y(obs.rel_pos_y), .rel_pos_z(obs.rel_pos_z),
    .rel_vel_x(obs.rel_vel_x), .rel_vel_y(obs.rel_vel_y), .rel_vel_z(obs.rel_vel_z),
    .bearing_threshold, .min_closing_speed, .recovery_speed,
    .no_closing_limit, .min_reseed_gap,
    .reseed_req(res.reseed_req), .reseed_cause(res.reseed_cause),
    .reseed_count(res.reseed_count), .bearing_delta(res.bearing_delta),
    .closing_speed(res.closing_speed), .stall_time(res.stall_time)
  );

  // never accept while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst) !(obs.ready && res.valid))
    else $error("accept while result pending");
  // a request always carries a cause
  a_cause: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.reseed_req == (res.reseed_cause != trm_pkg::CAUSE_NONE)))
    else $error("request and cause disagree");
  // no result in the cycle after an accept
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (obs.valid && obs.ready) |=> !res.valid)
    else $error("result too early");

endmodule

/* test/trm_checker.sv */
module trm_checker
  import trm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  trm_in_if    obs,
  trm_out_if   res,
  input  logic cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                   req;
    logic [CAUSE_BITS-1:0]  cause;
    logic [CNT_BITS-1:0]    count;
    logic [DELTA_BITS-1:0]  delta;
    logic [SPEED_BITS-1:0]  closing;
    logic [DUR_BITS-1:0]    stall;
  } verdict_t;

  // arctangent of 2^-i in 2^-32 turns
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // settings
  logic [15:0] thr;
  longint      min_spd, rec_spd;
  logic [39:0] nc_limit, rs_gap;

  // episode state
  logic [31:0] ep_epoch;
  logic [63:0] stall_t0, last_rs;
  logic [15:0] ref_hd;
  bit          ref_ok, stall_done;
  logic [31:0] rs_count;

  verdict_t due_q[$];

  function automatic logic [15:0] heading_of(input longint px, input longint py);
    longint x, y, xs, ys;
    logic [31:0] acc;
    x = px <<< 32;
    y = py <<< 32;
    acc = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + ATAN_TURNS[i];
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - ATAN_TURNS[i];
      end
    end
    acc = acc + 32'h0000_8000;
    return acc[31:16];
  endfunction

  function automatic longint root_of(input longint n);
    longint rt, b;
    rt = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= rt + b) begin
        n = n - (rt + b);
        rt = (rt >>> 1) + b;
      end else begin
        rt = rt >>> 1;
      end
      b = b >>> 2;
    end
    return rt;
  endfunction

  function automatic void clear_episode();
    ep_epoch = '0;
    stall_t0 = '0;
    last_rs = '0;
    ref_hd = '0;
    ref_ok = 0;
    stall_done = 0;
  endfunction

  // work out the result of one observation and advance the episode
  function automatic verdict_t advance(input logic act, input logic [62:0] stamp_in,
                                       input logic [31:0] epoch, input longint px,
                                       input longint py, input longint pz,
                                       input longint vx, input longint vy,
                                       input longint vz);
    verdict_t o;
    logic [15:0] hd;
    logic signed [15:0] d16;
    longint delta, r2, r, dot, mag, q, closing, adel;
    logic [63:0] st, dur;
    logic [CAUSE_BITS-1:0] why;
    o = '0;
    o.count = rs_count;
    delta = 0;
    dur = '0;
    why = CAUSE_NONE;
    st = {1'b0, stamp_in};
    if (!act || st == 0 || epoch == 0 || (px == 0 && py == 0)) begin
      clear_episode();
      return o;
    end
    hd = heading_of(px, py);
    if (ep_epoch != epoch) begin
      clear_episode();
      ep_epoch = epoch;
      ref_hd = hd;
      ref_ok = 1;
    end
    if (ref_ok) begin
      d16 = hd - ref_hd;
      delta = d16;
    end
    // range rounded to nearest, closing speed rounded to nearest with ties away from zero
    r2 = px * px + py * py + pz * pz;
    r = root_of(r2);
    if (r2 - r * r > r) r++;
    dot = px * vx + py * vy + pz * vz;
    mag = dot < 0 ? -dot : dot;
    q = (2 * mag + r) / (2 * r);
    if (q > 1048576) q = 1048576;
    closing = dot < 0 ? -q : q;
    if (closing > 1048575) closing = 1048575;
    // no-closing timer with hysteresis
    if (closing >= rec_spd) begin
      stall_t0 = '0;
      stall_done = 0;
    end else if (closing <= min_spd) begin
      if (stall_t0 == 0) stall_t0 = st;
      dur = st >= stall_t0 ? st - stall_t0 : '0;
    end else begin
      stall_t0 = '0;
    end
    o.delta = delta[15:0];
    o.closing = closing[20:0];
    o.stall = dur > 64'h00FF_FFFF_FFFF ? '1 : dur[39:0];
    // hold off while inside the reseed gap
    if (last_rs != 0 && (st < last_rs || st - last_rs < {24'b0, rs_gap})) return o;
    adel = delta < 0 ? -delta : delta;
    if (adel >= longint'(thr)) begin
      why = CAUSE_BEARING;
      ref_hd = hd;
    end else if (!stall_done && stall_t0 != 0 && dur >= {24'b0, nc_limit}) begin
      why = CAUSE_STALL;
      stall_done = 1;
    end
    if (why != CAUSE_NONE) begin
      if (why == CAUSE_BEARING && stall_t0 != 0) stall_t0 = st;
      rs_count = rs_count + 1;
      last_rs = st;
      o.req = 1'b1;
      o.cause = why;
      o.count = rs_count;
    end
    return o;
  endfunction

  // track settings, predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      clear_episode();
      rs_count = '0;
      thr = 16'd2731;
      min_spd = 0;
      rec_spd = 500;
      nc_limit = 40'd2000000000;
      rs_gap = 40'd1000000000;
      due_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BEARING_THRESHOLD: thr = cfg_data[15:0];
          REG_MIN_CLOSING_SPEED: min_spd = longint'($signed(cfg_data[20:0]));
          REG_RECOVERY_SPEED:    rec_spd = longint'($signed(cfg_data[20:0]));
          REG_NO_CLOSING_LIMIT:  nc_limit = cfg_data[39:0];
          REG_MIN_RESEED_GAP:    rs_gap = cfg_data[39:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        got = '{res.reseed_req, res.reseed_cause, res.reseed_count, res.bearing_delta,
                res.closing_speed, res.stall_time};
        if (due_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          want = due_q.pop_front();
          if (got.req !== want.req || got.cause !== want.cause ||
              got.count !== want.count || got.delta !== want.delta ||
              got.closing !== want.closing || got.stall !== want.stall) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: exp req %0d cause %0d count %0d delta %0d closing %0d stall %0d",
                       $realtime, want.req, want.cause, want.count, $signed(want.delta),
                       $signed(want.closing), want.stall);
              $display("                  got req %0d cause %0d count %0d delta %0d closing %0d stall %0d",
                       got.req, got.cause, got.count, $signed(got.delta),
                       $signed(got.closing), got.stall);
            end
          end
        end
      end
      if (obs.valid && obs.ready)
        due_q.push_back(advance(obs.active, obs.stamp, obs.sight_epoch,
                                longint'(obs.rel_pos_x), longint'(obs.rel_pos_y),
                                longint'(obs.rel_pos_z), longint'(obs.rel_vel_x),
                                longint'(obs.rel_vel_y), longint'(obs.rel_vel_z)));
    end
    pending = due_q.size();
  end

endmodule

/* test/tb.sv */
module tb;
  import trm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3000000;
  localparam int HOLD = 3000;
  localparam int SETTLE = 300;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int errors, pending;
  logic obs_fire;
  bit calm, hold_req;

  trm_in_if obs_if ();
  trm_out_if res_if ();

  tracking_reseed_monitor dut (
    .clk(clk), .rst(rst), .obs(obs_if.sink), .res(res_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  trm_checker chk (
    .clk(clk), .rst(rst), .obs(obs_if), .res(res_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // note each input transfer for the sender
  always @(posedge clk) obs_fire <= obs_if.valid && obs_if.ready;

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("tb: errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // result side: random stalls, long hold-off on request
  initial begin
    int gap;
    gap = 0;
    res_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        res_if.ready = 1'b0;
        repeat (HOLD) @(negedge clk);
        hold_req = 0;
      end else begin
        if (calm) begin
          res_if.ready = 1'b1;
        end else if (gap > 0) begin
          res_if.ready = 1'b0;
          gap--;
        end else begin
          res_if.ready = 1'b1;
          if ($urandom_range(0, 4) == 0) gap = pick_gap();
        end
        @(negedge clk);
      end
    end
  end

  task automatic put_obs(input logic a, input logic [62:0] st, input logic [31:0] ep,
                         input longint x, input longint y, input longint z,
                         input longint u, input longint v, input longint w);
    int g;
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      obs_if.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    obs_if.valid = 1'b1;
    obs_if.active = a;
    obs_if.stamp = st;
    obs_if.sight_epoch = ep;
    obs_if.rel_pos_x = x[23:0];
    obs_if.rel_pos_y = y[23:0];
    obs_if.rel_pos_z = z[23:0];
    obs_if.rel_vel_x = u[19:0];
    obs_if.rel_vel_y = v[19:0];
    obs_if.rel_vel_z = w[19:0];
    do @(negedge clk); while (!obs_fire);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    obs_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input longint val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[39:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic longint rand_base();
    longint m;
    m = 64'sd1 <<< $urandom_range(4, 23);
    return clamp(longint'($urandom_range(0, 32'hFFFF_FFFF)) % m - m / 2 * 2 + m / 2, 24);
  endfunction

  // episodes of coherent tracks with random content, salted with noise
  task automatic run_phase(input int n, input logic [63:0] dt_max, input bit pressure);
    logic [31:0] ep;
    logic [62:0] st;
    logic [63:0] r64;
    longint bx, by, bz, px, py, pz, nx, ny, nz;
    int mode, sh, sel;
    ep = 32'd1;
    st = 63'd1;
    bx = 1000;
    by = 1000;
    bz = 0;
    mode = 0;
    for (int k = 0; k < n; k++) begin
      if (pressure && k == n / 2) hold_req = 1;
      if (k == 0 || $urandom_range(0, 19) == 0) begin
        ep = $urandom_range(0, 99) == 0 ? 32'hFFFF_FFFF : $urandom_range(1, 32'hFFFF_FFFF);
        st = $urandom_range(0, 49) == 0 ? {31'h7FFF_FFFF, 32'h0} + $urandom :
             {23'b0, $urandom_range(0, 255), $urandom} + 63'd1;
        bx = rand_base();
        by = rand_base();
        bz = rand_base();
      end
      if ($urandom_range(0, 9) == 0) begin
        bx = rand_base();
        by = rand_base();
      end
      if ($urandom_range(0, 9) == 0) mode = $urandom_range(0, 2);
      r64 = {$urandom, $urandom};
      if ($urandom_range(0, 19) == 0) st = st - (r64 % (dt_max / 4 + 1));
      else st = st + r64 % (dt_max + 1);
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        put_obs($urandom, {$urandom, $urandom}, $urandom, $signed(24'($urandom)),
                $signed(24'($urandom)), $signed(24'($urandom)), $signed(20'($urandom)),
                $signed(20'($urandom)), $signed(20'($urandom)));
      end else if (sel < 5) begin
        put_obs(1'b0, st, ep, bx, by, bz, 0, 0, 0);
      end else if (sel < 6) begin
        put_obs(1'b1, 63'd0, ep, bx, by, bz, 1, 1, 1);
      end else if (sel < 7) begin
        put_obs(1'b1, st, 32'd0, bx, by, bz, 1, 1, 1);
      end else if (sel < 8) begin
        put_obs(1'b1, st, ep, 0, 0, bz, 5, 5, 5);
      end else begin
        nx = (bx >>> 10) + 1;
        ny = (by >>> 10) + 1;
        nz = (bz >>> 10) + 1;
        nx = nx < 0 ? -nx : nx;
        ny = ny < 0 ? -ny : ny;
        nz = nz < 0 ? -nz : nz;
        px = clamp(bx + longint'($urandom_range(0, 2 * nx)) - nx, 24);
        py = clamp(by + longint'($urandom_range(0, 2 * ny)) - ny, 24);
        pz = clamp(bz + longint'($urandom_range(0, 2 * nz)) - nz, 24);
        sh = $urandom_range(4, 14);
        case (mode)
          0: put_obs(1'b1, st, ep, px, py, pz, clamp(px >>> sh, 20), clamp(py >>> sh, 20),
                     clamp(pz >>> sh, 20));
          1: put_obs(1'b1, st, ep, px, py, pz, clamp(-(px >>> sh), 20),
                     clamp(-(py >>> sh), 20), clamp(-(pz >>> sh), 20));
          default: put_obs(1'b1, st, ep, px, py, pz, longint'($urandom_range(0, 800)) - 400,
                           longint'($urandom_range(0, 800)) - 400,
                           longint'($urandom_range(0, 800)) - 400);
        endcase
      end
    end
    drain();
  endtask

  initial begin
    longint thr_v [6] = '{2731, 1, 32768, 0, 2731, 800};
    longint min_v [6] = '{0, -1048575, 1048575, -300, -200, 100};
    longint rec_v [6] = '{500, 1048575, -1048575, 300, 200, 50};
    longint lim_v [6] = '{2000000000, 1, 40'hFF_FFFF_FFFF, 5000, 50000, 30000};
    longint gap_v [6] = '{1000000000, 0, 40'hFF_FFFF_FFFF, 0, 20000, 5000};
    logic [63:0] dt_v [6] = '{64'd800000000, 64'd1000, 64'h2000_0000_0000, 64'd3000,
                              64'd20000, 64'd10000};
    int num_v [6] = '{300, 250, 250, 250, 400, 250};
    rst = 1'b1;
    calm = 0;
    hold_req = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    obs_if.valid = 1'b0;
    obs_if.active = 1'b0;
    obs_if.stamp = '0;
    obs_if.sight_epoch = '0;
    obs_if.rel_pos_x = '0;
    obs_if.rel_pos_y = '0;
    obs_if.rel_pos_z = '0;
    obs_if.rel_vel_x = '0;
    obs_if.rel_vel_y = '0;
    obs_if.rel_vel_z = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: invalid kinds, extremes, stall and bearing reseeds, gate
    put_obs(1'b0, 63'd100, 32'd5, 1000, 0, 0, 0, 0, 0);
    put_obs(1'b1, 63'd0, 32'd5, 1000, 0, 0, 0, 0, 0);
    put_obs(1'b1, 63'd100, 32'd0, 1000, 0, 0, 0, 0, 0);
    put_obs(1'b1, 63'd100, 32'd5, 0, 0, 500, 3, 3, 3);
    put_obs(1'b1, 63'd1000000000, 32'd7, 8388607, 0, 0, -1000, 0, 0);
    put_obs(1'b1, 63'd2000000000, 32'd7, 8388607, 0, 0, -1000, 0, 0);
    put_obs(1'b1, 63'd3000000000, 32'd7, 8388607, 0, 0, -1000, 0, 0);
    put_obs(1'b1, 63'd3500000000, 32'd7, -8388608, -8388608, -8388608,
            524287, 524287, 524287);
    put_obs(1'b1, 63'd5000000000, 32'd7, -8388608, -8388608, -8388608,
            524287, 524287, 524287);
    put_obs(1'b1, 63'd4000000000, 32'd7, -8388608, -8388608, -8388608,
            524287, 524287, 524287);
    put_obs(1'b1, 63'd6500000000, 32'd7, -8388608, -8388608, -8388608,
            -524288, -524288, -524288);
    put_obs(1'b1, 63'd7000000000, 32'd7, -8388608, 100, 0, 0, 0, 0);
    put_obs(1'b1, 63'd7100000000, 32'd8, 0, 100, -5, 0, 0, 0);
    put_obs(1'b1, 63'd7200000000, 32'd8, 0, -100, 5, 0, 0, 0);
    put_obs(1'b1, 63'd7300000000, 32'd8, -1, 0, 8388607, 1, -1, 1);
    put_obs(1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 1, -1, 1);
    put_obs(1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8388607, 8388607, 8388607,
            -524288, 524287, -524288);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_BEARING_THRESHOLD, thr_v[p]);
      write_reg(REG_MIN_CLOSING_SPEED, min_v[p]);
      write_reg(REG_RECOVERY_SPEED, rec_v[p]);
      write_reg(REG_NO_CLOSING_LIMIT, lim_v[p]);
      write_reg(REG_MIN_RESEED_GAP, gap_v[p]);
      calm = (p == 5);
      run_phase(num_v[p], dt_v[p], p == 4);
    end

    if (errors == 0 && pending == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
